[hdl/in_order_response_reorder_buffer_unit_assert.svh]
// Assertion macros for the in-order response reorder buffer.
// Used by the top level; depends on nothing else.
`ifndef IN_ORDER_RESPONSE_REORDER_BUFFER_UNIT_ASSERT_SVH
`define IN_ORDER_RESPONSE_REORDER_BUFFER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IORRB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define IORRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/iorrb_pkg.sv]
// Shared types, sizes and codes of the in-order response reorder buffer.
// Used by the top level and the slot RAM instance; depends on nothing.
package iorrb_pkg;

   localparam int DEPTH    = 16;
   localparam int SEQ_BITS = 32;
   localparam int REF_BITS = 16;
   localparam int SLOT_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int RAM_W    = REF_BITS + 1;

   localparam logic ACTION_REQUEST  = 1'b0;
   localparam logic ACTION_RESPONSE = 1'b1;

   typedef enum logic [1:0] {
      KIND_ASSIGNED = 2'd0,
      KIND_SENT     = 2'd1,
      KIND_DROPPED  = 2'd2,
      KIND_REFUSED  = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   typedef struct packed {
      logic                action;
      logic [SEQ_BITS-1:0] seq_tag;
      logic [REF_BITS-1:0] response_ref;
      logic                keep_alive;
   } req_item_type;

   typedef struct packed {
      kind_type            kind;
      logic [SEQ_BITS-1:0] seq_number;
      logic [REF_BITS-1:0] out_ref;
      logic                close_after;
      logic                last;
   } rsp_item_type;

   // Ring addition: base plus an offset of at most DEPTH, wrapped once.
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (s >= (CNT_W + 1)'(DEPTH)) begin
         s = s - (CNT_W + 1)'(DEPTH);
      end
      return s[SLOT_W-1:0];
   endfunction

endpackage

[hdl/iorrb_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package needed.
module iorrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/in_order_response_reorder_buffer_unit.sv]
// Top level of the in-order response reorder buffer.
// Depends on iorrb_pkg, iorrb_ram and the assertion macro header.
//
//   Channel   Ports                            Direction   Carries
//   req       req_valid req_stall req_payload  in          request or response item
//   rsp       rsp_valid rsp_stall rsp_payload  out         result item
//
// An input item is taken while not stalled, and its result, if any, is registered
// in the output register; a response parked for a younger request gives none.
// Single-result items flow at one per cycle while the result side does not stall.
// A drain of N stored responses takes one slot RAM read per result, during which
// the input is stalled. Reset is synchronous and clears the counters, the ring
// position and the filled bits at once; the slot RAM needs no clearing pass.
// A stall on the result side holds the output register. Outside a drain, the
// input is stalled only while that register is full and cannot be emptied.
module in_order_response_reorder_buffer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  iorrb_pkg::req_item_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output iorrb_pkg::rsp_item_type rsp_payload
);

`include "in_order_response_reorder_buffer_unit_assert.svh"

   // Sequencer state and bookkeeping registers.
   iorrb_pkg::state_type                 state_ff, state_in;
   logic [iorrb_pkg::SEQ_BITS-1:0]       next_seq_ff, next_seq_in;
   logic [iorrb_pkg::SEQ_BITS-1:0]       head_seq_ff, head_seq_in;
   logic [iorrb_pkg::CNT_W-1:0]          pending_count_ff, pending_count_in;
   logic [iorrb_pkg::SLOT_W-1:0]         head_slot_ff, head_slot_in;
   logic [iorrb_pkg::DEPTH-1:0]          filled_ff, filled_in;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   iorrb_pkg::rsp_item_type              rsp_item_ff, rsp_item_in;

   // Slot RAM ports. Each word holds the keep-alive flag above the payload handle.
   logic                                 ram_wr_en;
   logic [iorrb_pkg::SLOT_W-1:0]         ram_wr_addr;
   logic [iorrb_pkg::RAM_W-1:0]          ram_wr_data;
   logic                                 ram_rd_en;
   logic [iorrb_pkg::RAM_W-1:0]          ram_rd_data;

   logic                                 out_free;
   logic                                 in_accept;

   // Values after removing the oldest pending entry.
   logic [iorrb_pkg::SLOT_W-1:0]         pop_slot;
   logic [iorrb_pkg::SEQ_BITS-1:0]       pop_seq;
   logic [iorrb_pkg::CNT_W-1:0]          pop_count;
   logic [iorrb_pkg::DEPTH-1:0]          pop_filled;
   logic                                 pop_more;

   // Response classification.
   logic [iorrb_pkg::SEQ_BITS-1:0]       tag_offset;
   logic                                 rsp_unmatched;
   logic [iorrb_pkg::SLOT_W-1:0]         store_slot;
   logic [iorrb_pkg::SLOT_W-1:0]         tail_slot;
   logic                                 buffer_full;

   iorrb_ram #(
      .WIDTH (iorrb_pkg::RAM_W),
      .DEPTH (iorrb_pkg::DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_slot_in),
      .rd_data (ram_rd_data)
   );

   // The output register can take a new item if it is empty or drains this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == iorrb_pkg::ST_IDLE) && out_free);
   assign in_accept = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   // Popping the head clears its filled bit and advances the ring by one.
   // A drain goes on while the new head is pending and already holds a response.
   always_comb begin
      pop_slot   = iorrb_pkg::slot_add(head_slot_ff, iorrb_pkg::CNT_W'(1));
      pop_seq    = head_seq_ff + iorrb_pkg::SEQ_BITS'(1);
      pop_count  = pending_count_ff - iorrb_pkg::CNT_W'(1);
      pop_filled = filled_ff;
      pop_filled[head_slot_ff] = 1'b0;
      pop_more   = (pop_count != '0) && pop_filled[pop_slot];
   end

   // A response matches only if its distance from the head is below the count.
   // That distance is then known to fit the count width.
   assign tag_offset    = req_payload.seq_tag - head_seq_ff;
   assign rsp_unmatched = (pending_count_ff == '0) ||
                          (tag_offset >= iorrb_pkg::SEQ_BITS'(pending_count_ff));
   assign store_slot    = iorrb_pkg::slot_add(head_slot_ff,
                                              tag_offset[iorrb_pkg::CNT_W-1:0]);
   assign tail_slot     = iorrb_pkg::slot_add(head_slot_ff, pending_count_ff);
   assign buffer_full   = (pending_count_ff == iorrb_pkg::CNT_W'(iorrb_pkg::DEPTH));

   assign ram_wr_addr = store_slot;
   assign ram_wr_data = {req_payload.keep_alive, req_payload.response_ref};

   // Writes happen only when an item is taken in the idle state and reads only
   // for a drain, so a write and a read of the same slot never share a cycle.
   always_comb begin
      state_in         = state_ff;
      next_seq_in      = next_seq_ff;
      head_seq_in      = head_seq_ff;
      pending_count_in = pending_count_ff;
      head_slot_in     = head_slot_ff;
      filled_in        = filled_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_item_in      = rsp_item_ff;
      ram_wr_en        = 1'b0;
      ram_rd_en        = 1'b0;

      unique case (state_ff)
         iorrb_pkg::ST_IDLE: begin
            if (in_accept) begin
               rsp_item_in.out_ref     = '0;
               rsp_item_in.close_after = 1'b0;
               rsp_item_in.last        = 1'b1;
               if (req_payload.action == iorrb_pkg::ACTION_REQUEST) begin
                  rsp_valid_in = 1'b1;
                  if (buffer_full) begin
                     rsp_item_in.kind       = iorrb_pkg::KIND_REFUSED;
                     rsp_item_in.seq_number = '0;
                  end else begin
                     next_seq_in            = next_seq_ff + iorrb_pkg::SEQ_BITS'(1);
                     filled_in[tail_slot]   = 1'b0;
                     pending_count_in       = pending_count_ff + iorrb_pkg::CNT_W'(1);
                     rsp_item_in.kind       = iorrb_pkg::KIND_ASSIGNED;
                     rsp_item_in.seq_number = next_seq_in;
                  end
               end else if (rsp_unmatched) begin
                  rsp_valid_in           = 1'b1;
                  rsp_item_in.kind       = iorrb_pkg::KIND_DROPPED;
                  rsp_item_in.seq_number = req_payload.seq_tag;
                  rsp_item_in.out_ref    = req_payload.response_ref;
               end else if (tag_offset != '0) begin
                  // A younger request: park the response in its slot.
                  ram_wr_en             = 1'b1;
                  filled_in[store_slot] = 1'b1;
               end else begin
                  // The oldest request is answered: send it and pop the head.
                  rsp_valid_in            = 1'b1;
                  rsp_item_in.kind        = iorrb_pkg::KIND_SENT;
                  rsp_item_in.seq_number  = head_seq_ff;
                  rsp_item_in.out_ref     = req_payload.response_ref;
                  rsp_item_in.close_after = !req_payload.keep_alive;
                  rsp_item_in.last        = !pop_more;
                  head_slot_in            = pop_slot;
                  head_seq_in             = pop_seq;
                  pending_count_in        = pop_count;
                  filled_in               = pop_filled;
                  if (pop_more) begin
                     ram_rd_en = 1'b1;
                     state_in  = iorrb_pkg::ST_DRAIN;
                  end
               end
            end
         end
         iorrb_pkg::ST_DRAIN: begin
            // The head slot was read on the previous edge; the RAM output holds
            // until the output register has room.
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.kind        = iorrb_pkg::KIND_SENT;
               rsp_item_in.seq_number  = head_seq_ff;
               rsp_item_in.out_ref     = ram_rd_data[iorrb_pkg::REF_BITS-1:0];
               rsp_item_in.close_after = !ram_rd_data[iorrb_pkg::REF_BITS];
               rsp_item_in.last        = !pop_more;
               head_slot_in            = pop_slot;
               head_seq_in             = pop_seq;
               pending_count_in        = pop_count;
               filled_in               = pop_filled;
               if (pop_more) begin
                  ram_rd_en = 1'b1;
               end else begin
                  state_in = iorrb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = iorrb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= iorrb_pkg::ST_IDLE;
         next_seq_ff      <= '0;
         head_seq_ff      <= iorrb_pkg::SEQ_BITS'(1);
         pending_count_ff <= '0;
         head_slot_ff     <= '0;
         filled_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         next_seq_ff      <= next_seq_in;
         head_seq_ff      <= head_seq_in;
         pending_count_ff <= pending_count_in;
         head_slot_ff     <= head_slot_in;
         filled_ff        <= filled_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // The pending count never passes the ring size.
   `IORRB_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      pending_count_ff <= iorrb_pkg::CNT_W'(iorrb_pkg::DEPTH),
      "pending count exceeds the ring depth")

   // The numbers from head to last assigned are exactly the pending ones.
   `IORRB_ASSERT_NOW(a_seq_window, clock, reset, 1'b1,
      (next_seq_ff - head_seq_ff + iorrb_pkg::SEQ_BITS'(1)) ==
         iorrb_pkg::SEQ_BITS'(pending_count_ff),
      "sequence window disagrees with the pending count")

   // A drain only runs while the head slot holds a stored response.
   `IORRB_ASSERT_NOW(a_drain_head, clock, reset, state_ff == iorrb_pkg::ST_DRAIN,
      (pending_count_ff != '0) && filled_ff[head_slot_ff],
      "drain without a stored response at the head")

   // A request into a full ring is refused on the next edge.
   `IORRB_ASSERT_NEXT(a_full_refuse, clock, reset,
      in_accept && (req_payload.action == iorrb_pkg::ACTION_REQUEST) && buffer_full,
      rsp_valid_ff && (rsp_item_ff.kind == iorrb_pkg::KIND_REFUSED),
      "request into a full ring was not refused")

endmodule
